// ===== rtl/frw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frw_pkg: shared types and constants of the flight recorder ring writer
// Header field positions, length limits, the header packer and the command and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package frw_pkg;

  // Default ring size as log2 of the word count
  localparam int unsigned RING_LOG2_DEF = 12;

  // Field widths
  localparam int unsigned WORD_W = 64;
  localparam int unsigned LEN_W  = 10;
  localparam int unsigned TYPE_W = 4;
  localparam int unsigned CODE_W = 13;

  // Header bit positions
  localparam int unsigned HDR_LEN_LSB  = 54;
  localparam int unsigned HDR_USER_BIT = 53;
  localparam int unsigned HDR_TYPE_LSB = 49;
  localparam int unsigned HDR_CODE_LSB = 36;

  // Payload length limit and header/timestamp overhead
  localparam logic [LEN_W-1:0] MAX_PAYLOAD = 10'd1021;
  localparam logic [LEN_W-1:0] EVENT_OVERHEAD = 10'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture the input item
    logic close;       // publish an event that was left open
    logic plan;        // work out padding and walk threshold
    logic gap_capture; // register tail minus head
    logic head_step;   // advance head by the stored header length
    logic wr_pay;      // write one payload word
    logic wr_pad;      // write the padding header
    logic wr_hdr;      // write the event header
    logic wr_stamp;    // write the timestamp
  } frw_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic open_event;  // payload words still outstanding
    logic walk_more;   // head must move before the event fits
    logic pad_needed;  // event would straddle the ring end
    logic slot_free;   // output register can take a word
  } frw_sts_t;

  // Pack an event header word
  function automatic logic [WORD_W-1:0] pack_header(
    input logic [LEN_W-1:0]  total,
    input logic              user_flag,
    input logic [TYPE_W-1:0] ev_type,
    input logic [CODE_W-1:0] ev_code
  );
    logic [WORD_W-1:0] hdr;
    hdr = '0;
    hdr[HDR_LEN_LSB +: LEN_W]   = total;
    hdr[HDR_USER_BIT]           = user_flag;
    hdr[HDR_TYPE_LSB +: TYPE_W] = ev_type;
    hdr[HDR_CODE_LSB +: CODE_W] = ev_code;
    return hdr;
  endfunction

endpackage

// ===== rtl/frw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frw_ctrl: sequencer of the flight recorder ring writer
// Steps a begin item through close, planning, head walk and the word writes,
// and a payload item to its word write, issuing one command bundle per cycle.
// ----------------------------------------------------------------------------
module frw_ctrl
  import frw_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     func_i,
  input  frw_sts_t sts_i,
  output frw_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_PLAN,
    ST_CHECK,
    ST_STEP,
    ST_PAD,
    ST_HDR,
    ST_STAMP,
    ST_PAY
  } state_e;

  state_e state_q, state_d;

  // Decode commands and next state
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = func_i ? ST_PAY : ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        cmd_o.close = 1'b1;
        state_d     = ST_PLAN;
      end
      ST_PLAN: begin
        cmd_o.plan = 1'b1;
        state_d    = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.gap_capture = 1'b1;
        if (sts_i.walk_more) begin
          state_d = ST_STEP;
        end else if (sts_i.pad_needed) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_HDR;
        end
      end
      ST_STEP: begin
        cmd_o.head_step = 1'b1;
        state_d         = ST_CHECK;
      end
      ST_PAD: begin
        if (sts_i.slot_free) begin
          cmd_o.wr_pad = 1'b1;
          state_d      = ST_HDR;
        end
      end
      ST_HDR: begin
        if (sts_i.slot_free) begin
          cmd_o.wr_hdr = 1'b1;
          state_d      = ST_STAMP;
        end
      end
      ST_STAMP: begin
        if (sts_i.slot_free) begin
          cmd_o.wr_stamp = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_PAY: begin
        // drop a payload item that has no open event
        if (!sts_i.open_event) begin
          state_d = ST_IDLE;
        end else if (sts_i.slot_free) begin
          cmd_o.wr_pay = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/frw_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frw_datapath: ring store, counters and output register
// Holds the ring memory, the head and tail counters, the open event state and
// the result register, and carries out the commands of the controller.
// ----------------------------------------------------------------------------
module frw_datapath
  import frw_pkg::*;
#(
  parameter int unsigned RING_LOG2 = RING_LOG2_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  frw_cmd_t             cmd_i,
  output frw_sts_t             sts_o,
  input  logic                 user_event_i,
  input  logic [TYPE_W-1:0]    event_type_i,
  input  logic [CODE_W-1:0]    event_code_i,
  input  logic [LEN_W-1:0]     payload_len_i,
  input  logic [WORD_W-1:0]    stamp_i,
  input  logic [WORD_W-1:0]    payload_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [RING_LOG2-1:0] word_addr_o,
  output logic [WORD_W-1:0]    word_data_o,
  output logic                 is_padding_o,
  output logic [WORD_W-1:0]    head_index_o,
  output logic [WORD_W-1:0]    tail_index_o,
  output logic                 last_o
);

  localparam int unsigned AW = RING_LOG2;
  localparam int unsigned DEPTH = 1 << AW;
  localparam logic [AW:0] RING_SIZE = {1'b1, {AW{1'b0}}};

  // Ring store
  logic [WORD_W-1:0] ring_mem [DEPTH];
  logic [WORD_W-1:0] rd_data_q;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;

  // Captured item
  logic              user_q;
  logic [TYPE_W-1:0] type_q;
  logic [CODE_W-1:0] code_q;
  logic [LEN_W-1:0]  len_q;
  logic [WORD_W-1:0] stamp_q;
  logic [WORD_W-1:0] pword_q;

  // Event and ring state
  logic [WORD_W-1:0] head_q, head_d;
  logic [WORD_W-1:0] tail_q, tail_d;
  logic [AW-1:0]     woff_q, woff_d;
  logic [LEN_W-1:0]  left_q, left_d;
  logic [LEN_W-1:0]  evw_q, evw_d;
  logic [AW-1:0]     toff_q, toff_d;
  logic [LEN_W-1:0]  pad_q;
  logic [AW:0]       thresh_q;
  logic [WORD_W-1:0] gap_q;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic              slot_free;
  logic              emit;
  logic [AW-1:0]     out_addr_q;
  logic [WORD_W-1:0] out_data_q;
  logic              out_pad_q;
  logic [WORD_W-1:0] out_head_q;
  logic [WORD_W-1:0] out_tail_q;
  logic              out_last_q;

  // Planning and walk terms
  logic [LEN_W-1:0]  len_clamped;
  logic [LEN_W-1:0]  total_w;
  logic [AW:0]       dist_w;
  logic [LEN_W-1:0]  pad_w;
  logic [LEN_W:0]    need_w;
  logic [AW:0]       thresh_w;
  logic [WORD_W-1:0] gap_w;
  logic              walk_more;
  logic [LEN_W-1:0]  stored_len;
  logic [LEN_W-1:0]  step_w;
  logic [LEN_W-1:0]  tail_add;

  assign len_clamped = (payload_len_i > MAX_PAYLOAD) ? MAX_PAYLOAD : payload_len_i;
  assign total_w     = len_q + EVENT_OVERHEAD;

  // Padding covers the rest of the ring when the event would straddle its end
  assign dist_w   = RING_SIZE - {1'b0, tail_q[AW-1:0]};
  assign pad_w    = (dist_w < {{(AW-9){1'b0}}, total_w}) ? dist_w[LEN_W-1:0] : '0;
  assign need_w   = {1'b0, total_w} + {1'b0, pad_w};
  assign thresh_w = RING_SIZE - {{(AW-LEN_W){1'b0}}, need_w};

  // Walk while the used span plus the new words would fill the ring
  assign gap_w     = tail_q - head_q;
  assign walk_more = (gap_w != '0) &&
                     ((|gap_w[WORD_W-1:AW+1]) || (gap_w[AW:0] >= thresh_q));

  // Head step: stored length, zero taken as one, never past the tail
  assign stored_len = rd_data_q[HDR_LEN_LSB +: LEN_W];
  always_comb begin
    step_w = (stored_len == '0) ? LEN_W'(1) : stored_len;
    if ((gap_q[WORD_W-1:LEN_W] == '0) && (gap_q[LEN_W-1:0] < step_w)) begin
      step_w = gap_q[LEN_W-1:0];
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;
  assign emit      = cmd_i.wr_pay | cmd_i.wr_pad | cmd_i.wr_hdr | cmd_i.wr_stamp;

  // Next state of counters and ring write
  always_comb begin
    head_d   = head_q;
    woff_d   = woff_q;
    left_d   = left_q;
    evw_d    = evw_q;
    toff_d   = toff_q;
    tail_add = '0;
    wr_en    = 1'b0;
    wr_addr  = toff_q;
    wr_data  = stamp_q;
    if (cmd_i.close && (left_q != '0)) begin
      tail_add = evw_q;
      left_d   = '0;
    end
    if (cmd_i.plan) begin
      toff_d = tail_q[AW-1:0];
    end
    if (cmd_i.head_step) begin
      head_d = head_q + {{(WORD_W-LEN_W){1'b0}}, step_w};
    end
    if (cmd_i.wr_pay) begin
      wr_en   = 1'b1;
      wr_addr = woff_q;
      wr_data = pword_q;
      left_d  = left_q - LEN_W'(1);
      woff_d  = woff_q + AW'(1);
      if (left_q == LEN_W'(1)) begin
        tail_add = evw_q;
      end
    end
    if (cmd_i.wr_pad) begin
      wr_en    = 1'b1;
      wr_data  = {pad_q, {HDR_LEN_LSB{1'b0}}};
      tail_add = pad_q;
      toff_d   = '0;
    end
    if (cmd_i.wr_hdr) begin
      wr_en   = 1'b1;
      wr_data = pack_header(total_w, user_q, type_q, code_q);
      toff_d  = toff_q + AW'(1);
    end
    if (cmd_i.wr_stamp) begin
      wr_en   = 1'b1;
      wr_data = stamp_q;
      toff_d  = toff_q + AW'(1);
      if (len_q == '0) begin
        tail_add = total_w;
      end else begin
        woff_d = toff_q + AW'(1);
        left_d = len_q;
        evw_d  = total_w;
      end
    end
  end

  assign tail_d = tail_q + {{(WORD_W-LEN_W){1'b0}}, tail_add};

  // Output valid: set on a write, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      woff_q      <= '0;
      left_q      <= '0;
      evw_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      woff_q      <= woff_d;
      left_q      <= left_d;
      evw_q       <= evw_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture item, plan and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      user_q  <= user_event_i;
      type_q  <= event_type_i;
      code_q  <= event_code_i;
      len_q   <= len_clamped;
      stamp_q <= stamp_i;
      pword_q <= payload_word_i;
    end
    toff_q <= toff_d;
    if (cmd_i.plan) begin
      pad_q    <= pad_w;
      thresh_q <= thresh_w;
    end
    if (cmd_i.gap_capture) begin
      gap_q <= gap_w;
    end
    if (emit) begin
      out_addr_q <= wr_addr;
      out_data_q <= wr_data;
      out_pad_q  <= cmd_i.wr_pad;
      out_head_q <= head_q;
      out_tail_q <= tail_d;
      out_last_q <= cmd_i.wr_pay | cmd_i.wr_stamp;
    end
  end

  // Ring memory: one write port, registered read at the head
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= ring_mem[head_q[AW-1:0]];
  end

  assign sts_o.open_event = (left_q != '0);
  assign sts_o.walk_more  = walk_more;
  assign sts_o.pad_needed = (pad_q != '0);
  assign sts_o.slot_free  = slot_free;

  assign out_valid_o  = out_valid_q;
  assign word_addr_o  = out_addr_q;
  assign word_data_o  = out_data_q;
  assign is_padding_o = out_pad_q;
  assign head_index_o = out_head_q;
  assign tail_index_o = out_tail_q;
  assign last_o       = out_last_q;

endmodule

// ===== rtl/flight_recorder_ring_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flight_recorder_ring_writer: overwriting trace ring writer
// Records trace events into a ring of 64-bit words and reports every write.
// ----------------------------------------------------------------------------
// A payload item is accepted and its word written. A begin item goes through
// accept, close, plan, check, header and timestamp, adding a padding header
// when one is needed and a step for every old event the head walks past: each
// step reads the stored header at the head through the single read port of
// the ring memory and adds its length to the head. A stalled output holds the
// sequence while a word waits to be taken. One item is in work at a time; the
// output register lets the next item in while the last word is still held.
// The ring memory has no reset; the head walk only reads words written before.
module flight_recorder_ring_writer
  import frw_pkg::*;
#(
  parameter int unsigned RING_LOG2 = RING_LOG2_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 func_i,
  input  logic                 user_event_i,
  input  logic [TYPE_W-1:0]    event_type_i,
  input  logic [CODE_W-1:0]    event_code_i,
  input  logic [LEN_W-1:0]     payload_len_i,
  input  logic [WORD_W-1:0]    stamp_i,
  input  logic [WORD_W-1:0]    payload_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [RING_LOG2-1:0] word_addr_o,
  output logic [WORD_W-1:0]    word_data_o,
  output logic                 is_padding_o,
  output logic [WORD_W-1:0]    head_index_o,
  output logic [WORD_W-1:0]    tail_index_o,
  output logic                 last_o
);

  frw_cmd_t cmd;
  frw_sts_t sts;

  // Sequence each item
  frw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Ring, counters and result register
  frw_datapath #(
    .RING_LOG2 (RING_LOG2)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .user_event_i   (user_event_i),
    .event_type_i   (event_type_i),
    .event_code_i   (event_code_i),
    .payload_len_i  (payload_len_i),
    .stamp_i        (stamp_i),
    .payload_word_i (payload_word_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .word_addr_o    (word_addr_o),
    .word_data_o    (word_data_o),
    .is_padding_o   (is_padding_o),
    .head_index_o   (head_index_o),
    .tail_index_o   (tail_index_o),
    .last_o         (last_o)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the flight recorder ring writer
// Drives a directed table of begin and payload items, then random event
// sequences with random gaps on both handshakes. Each accepted item is run
// through a shadow copy of the ring, head, tail and open event. The words
// that it writes are queued, and every word the block reports is compared
// field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module testbench;
  import frw_pkg::*;

  localparam int unsigned RLOG = RING_LOG2_DEF;
  localparam longint unsigned RING_WORDS = 64'd1 << RLOG;
  localparam bit FUNC_BEGIN   = 1'b0;
  localparam bit FUNC_PAYLOAD = 1'b1;
  localparam int unsigned RANDOM_ITEMS = 190;
  localparam int unsigned TAIL_CYCLES  = 40;

  // One input item, with an optional typed header expectation
  typedef struct {
    bit              func;
    bit              user;
    bit [TYPE_W-1:0] etype;
    bit [CODE_W-1:0] code;
    bit [LEN_W-1:0]  len;
    bit [WORD_W-1:0] stamp;
    bit [WORD_W-1:0] pword;
    bit              fixed;
    bit [RLOG-1:0]   exp_addr;
    bit [WORD_W-1:0] exp_data;
  } stim_t;

  // One ring write as the block reports it
  typedef struct {
    bit [RLOG-1:0]   addr;
    bit [WORD_W-1:0] data;
    bit              pad;
    bit [WORD_W-1:0] head;
    bit [WORD_W-1:0] tail;
    bit              last;
  } ring_write_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              func_i;
  logic              user_event_i;
  logic [TYPE_W-1:0] event_type_i;
  logic [CODE_W-1:0] event_code_i;
  logic [LEN_W-1:0]  payload_len_i;
  logic [WORD_W-1:0] stamp_i;
  logic [WORD_W-1:0] payload_word_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [RLOG-1:0]   word_addr_o;
  logic [WORD_W-1:0] word_data_o;
  logic              is_padding_o;
  logic [WORD_W-1:0] head_index_o;
  logic [WORD_W-1:0] tail_index_o;
  logic              last_o;

  // Shadow state of the ring writer
  bit [WORD_W-1:0] ring_copy [RING_WORDS];
  bit [WORD_W-1:0] head_ctr;
  bit [WORD_W-1:0] tail_ctr;
  bit [RLOG-1:0]   pay_off;
  bit [LEN_W-1:0]  words_open;
  bit [LEN_W-1:0]  open_total;

  ring_write_t pending_writes [$];
  stim_t       directed_rows [$];
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned burst_left;

  flight_recorder_ring_writer #(
    .RING_LOG2(RLOG)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .user_event_i  (user_event_i),
    .event_type_i  (event_type_i),
    .event_code_i  (event_code_i),
    .payload_len_i (payload_len_i),
    .stamp_i       (stamp_i),
    .payload_word_i(payload_word_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .word_addr_o   (word_addr_o),
    .word_data_o   (word_data_o),
    .is_padding_o  (is_padding_o),
    .head_index_o  (head_index_o),
    .tail_index_o  (tail_index_o),
    .last_o        (last_o)
  );

  // Free-running clock, 12 ns period
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop for a hung run
  initial begin
    #15_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic bit [WORD_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Queue one ring write with the counters as they stand now
  task automatic push_write(input bit [RLOG-1:0] addr, input bit [WORD_W-1:0] data,
                            input bit pad);
    ring_write_t w;
    w.addr = addr;
    w.data = data;
    w.pad  = pad;
    w.head = head_ctr;
    w.tail = tail_ctr;
    w.last = 1'b0;
    pending_writes.push_back(w);
  endtask

  // Work out every ring write that one accepted item causes
  task automatic forecast_writes(input stim_t s);
    bit [WORD_W-1:0] len;
    bit [WORD_W-1:0] total;
    bit [WORD_W-1:0] toff;
    bit [WORD_W-1:0] room;
    bit [WORD_W-1:0] pad;
    bit [WORD_W-1:0] gap;
    bit [WORD_W-1:0] step;
    bit [WORD_W-1:0] hdr;
    int              first;
    first = pending_writes.size();
    if (s.func == FUNC_PAYLOAD) begin
      // Drop a payload word when no event is open
      if (words_open == 0) return;
      ring_copy[pay_off] = s.pword;
      words_open--;
      if (words_open == 0) tail_ctr += WORD_W'(open_total);
      push_write(pay_off, s.pword, 1'b0);
      pay_off++;
    end else begin
      // Close an event that is still missing words
      if (words_open != 0) begin
        tail_ctr += WORD_W'(open_total);
        words_open = '0;
      end
      len = WORD_W'(s.len);
      if (len > WORD_W'(MAX_PAYLOAD)) len = WORD_W'(MAX_PAYLOAD);
      total = len + WORD_W'(EVENT_OVERHEAD);
      toff  = tail_ctr & (RING_WORDS - 1);
      room  = RING_WORDS - toff;
      pad   = (room < total) ? room : 64'd0;
      // Advance the head over stored headers until the event fits
      while (1) begin
        gap = tail_ctr - head_ctr;
        if (gap == 0 || gap + total + pad < RING_WORDS) break;
        step = ring_copy[head_ctr[RLOG-1:0]] >> HDR_LEN_LSB;
        if (step == 0) step = 1;
        if (step > gap) step = gap;
        head_ctr += step;
      end
      // Pad out the ring end
      if (pad != 0) begin
        ring_copy[toff[RLOG-1:0]] = pad << HDR_LEN_LSB;
        tail_ctr += pad;
        push_write(toff[RLOG-1:0], pad << HDR_LEN_LSB, 1'b1);
        toff = 0;
      end
      hdr = {total[LEN_W-1:0], s.user, s.etype, s.code, 36'd0};
      ring_copy[toff[RLOG-1:0]] = hdr;
      push_write(toff[RLOG-1:0], hdr, 1'b0);
      toff = (toff + 1) & (RING_WORDS - 1);
      ring_copy[toff[RLOG-1:0]] = s.stamp;
      if (len == 0) tail_ctr += total;
      push_write(toff[RLOG-1:0], s.stamp, 1'b0);
      toff = (toff + 1) & (RING_WORDS - 1);
      if (len != 0) begin
        pay_off    = toff[RLOG-1:0];
        words_open = len[LEN_W-1:0];
        open_total = total[LEN_W-1:0];
      end
    end
    pending_writes[pending_writes.size()-1].last = 1'b1;
    // Typed header expectation takes the place of the forecast one
    if (s.fixed) begin
      pending_writes[first].addr = s.exp_addr;
      pending_writes[first].data = s.exp_data;
    end
  endtask

  // Gap before the next item: mostly short, a few long, some bursts
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) begin
      burst_left = $urandom_range(60, 20);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  // Present one item and hold it until taken
  task automatic send_item(input stim_t s);
    int unsigned g;
    if (!(s.func == FUNC_PAYLOAD && words_open == 0)) items_sent++;
    g = pick_gap();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= s.func;
    user_event_i   <= s.user;
    event_type_i   <= s.etype;
    event_code_i   <= s.code;
    payload_len_i  <= s.len;
    stamp_i        <= s.stamp;
    payload_word_i <= s.pword;
    do @(negedge clk_i); while (!in_ready_o);
    forecast_writes(s);
    @(posedge clk_i);
  endtask

  // Hold the sender until every queued write has come out
  task automatic drain_writes();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_writes.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_row(input bit func, input bit user, input bit [TYPE_W-1:0] etype,
                         input bit [CODE_W-1:0] code, input bit [LEN_W-1:0] len,
                         input bit [WORD_W-1:0] stamp, input bit [WORD_W-1:0] pword,
                         input bit fixed, input bit [RLOG-1:0] exp_addr,
                         input bit [WORD_W-1:0] exp_data);
    stim_t s;
    s.func     = func;
    s.user     = user;
    s.etype    = etype;
    s.code     = code;
    s.len      = len;
    s.stamp    = stamp;
    s.pword    = pword;
    s.fixed    = fixed;
    s.exp_addr = exp_addr;
    s.exp_data = exp_data;
    directed_rows.push_back(s);
  endtask

  function automatic stim_t rand_item(input bit func, input bit [LEN_W-1:0] len);
    stim_t s;
    s.func  = func;
    s.user  = 1'($urandom_range(1));
    s.etype = TYPE_W'($urandom());
    s.code  = CODE_W'($urandom());
    s.len   = len;
    s.stamp = rand_word();
    s.pword = rand_word();
    s.fixed = 1'b0;
    s.exp_addr = '0;
    s.exp_data = '0;
    return s;
  endfunction

  // One random event: mostly well formed, some cut short, some noise
  task automatic run_random_event();
    int unsigned kind;
    int unsigned r;
    int unsigned len;
    int unsigned npay;
    kind = $urandom_range(99);
    if (kind < 5) begin
      send_item(rand_item(FUNC_PAYLOAD, LEN_W'($urandom())));
    end else if (kind < 10) begin
      send_item(rand_item(FUNC_BEGIN, LEN_W'($urandom())));
    end else begin
      r = $urandom_range(99);
      if (r < 65) len = $urandom_range(4, 0);
      else if (r < 85) len = $urandom_range(24, 5);
      else if (r < 93) len = $urandom_range(120, 25);
      else len = $urandom_range(1021, 900);
      if (len > 24) begin
        npay = $urandom_range(4, 0);
        if (npay > len) npay = len;
      end else if (kind < 25) begin
        npay = $urandom_range(len, 0);
      end else begin
        npay = len;
      end
      send_item(rand_item(FUNC_BEGIN, LEN_W'(len)));
      repeat (npay) send_item(rand_item(FUNC_PAYLOAD, LEN_W'($urandom())));
    end
    if ($urandom_range(99) < 3) drain_writes();
  endtask

  // Stall the result side: mostly short, a few long, some open stretches
  initial begin : result_stall
    int unsigned low_n;
    int unsigned high_n;
    int unsigned r;
    out_ready_i = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      r = $urandom_range(99);
      if (r < 45) low_n = 0;
      else if (r < 80) low_n = $urandom_range(2, 1);
      else if (r < 93) low_n = $urandom_range(8, 3);
      else low_n = $urandom_range(60, 20);
      high_n = ($urandom_range(99) < 10) ? 150 : $urandom_range(12, 1);
      if (low_n != 0) begin
        out_ready_i <= 1'b0;
        repeat (low_n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat (high_n) @(posedge clk_i);
    end
  end

  // Compare each taken word with the oldest queued write
  always @(negedge clk_i) begin : write_check
    ring_write_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected write: word_addr %0h word_data %0h", word_addr_o, word_data_o);
        mismatches++;
      end else begin
        w = pending_writes.pop_front();
        if (word_addr_o !== w.addr) begin
          $error("word_addr: expected %0h, got %0h", w.addr, word_addr_o);
          mismatches++;
        end
        if (word_data_o !== w.data) begin
          $error("word_data: expected %0h, got %0h", w.data, word_data_o);
          mismatches++;
        end
        if (is_padding_o !== w.pad) begin
          $error("is_padding: expected %0h, got %0h", w.pad, is_padding_o);
          mismatches++;
        end
        if (head_index_o !== w.head) begin
          $error("head_index: expected %0h, got %0h", w.head, head_index_o);
          mismatches++;
        end
        if (tail_index_o !== w.tail) begin
          $error("tail_index: expected %0h, got %0h", w.tail, tail_index_o);
          mismatches++;
        end
        if (last_o !== w.last) begin
          $error("last: expected %0h, got %0h", w.last, last_o);
          mismatches++;
        end
      end
    end
  end

  // Reset, directed table, random events, final verdict
  initial begin : stimulus
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    func_i         = FUNC_BEGIN;
    user_event_i   = 1'b0;
    event_type_i   = '0;
    event_code_i   = '0;
    payload_len_i  = '0;
    stamp_i        = '0;
    payload_word_i = '0;
    mismatches     = 0;
    items_sent     = 0;
    burst_left     = 0;
    head_ctr       = '0;
    tail_ctr       = '0;
    pay_off        = '0;
    words_open     = '0;
    open_total     = '0;
    foreach (ring_copy[i]) ring_copy[i] = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Stray payload right after reset writes nothing
    add_row(FUNC_PAYLOAD, 1'b0, 4'h0, 13'h0000, 10'd0, '0, '1, 1'b0, '0, '0);
    // Runtime event of the internal type with id 0, no payload
    add_row(FUNC_BEGIN, 1'b0, 4'h0, 13'h0000, 10'd0, '0, '0,
            1'b1, 12'h000, 64'h0080_0000_0000_0000);
    // User, type and code header fields at their top value, one payload word
    add_row(FUNC_BEGIN, 1'b1, 4'hF, 13'h1FFF, 10'd1, '1, '0,
            1'b1, 12'h002, 64'h00FF_FFF0_0000_0000);
    add_row(FUNC_PAYLOAD, 1'b0, 4'h0, 13'h0000, 10'd0, '0, '1, 1'b0, '0, '0);
    add_row(FUNC_PAYLOAD, 1'b1, 4'hF, 13'h1FFF, 10'h3FF, '1, '0, 1'b0, '0, '0);
    // Event cut short by the next begin
    add_row(FUNC_BEGIN, 1'b0, 4'h5, 13'h0AAA, 10'd3, 64'h5555_5555_5555_5555,
            '0, 1'b0, '0, '0);
    add_row(FUNC_PAYLOAD, 1'b0, 4'h0, 13'h0000, 10'd0, '0,
            64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0, '0);
    // Oversized lengths fill the ring fast when closed early
    add_row(FUNC_BEGIN, 1'b1, 4'hA, 13'h1555, 10'h3FF, 64'h0123_4567_89AB_CDEF,
            '0, 1'b0, '0, '0);
    add_row(FUNC_PAYLOAD, 1'b0, 4'h0, 13'h0000, 10'd0, '0,
            64'hFEDC_BA98_7654_3210, 1'b0, '0, '0);
    add_row(FUNC_BEGIN, 1'b0, 4'h3, 13'h0001, 10'h3FE, '1, '0, 1'b0, '0, '0);
    add_row(FUNC_BEGIN, 1'b1, 4'hC, 13'h1000, 10'd1021, '0, '0, 1'b0, '0, '0);
    add_row(FUNC_BEGIN, 1'b0, 4'h7, 13'h0F0F, 10'd1000, rand_word(), '0,
            1'b0, '0, '0);
    // Straddles the ring end: the head walks old events, then padding
    add_row(FUNC_BEGIN, 1'b1, 4'h9, 13'h0123, 10'd20, rand_word(), '0,
            1'b0, '0, '0);
    add_row(FUNC_PAYLOAD, 1'b0, 4'h0, 13'h0000, 10'd0, '0, rand_word(), 1'b0, '0, '0);
    add_row(FUNC_PAYLOAD, 1'b0, 4'h0, 13'h0000, 10'd0, '0, rand_word(), 1'b0, '0, '0);
    add_row(FUNC_BEGIN, 1'b0, 4'h0, 13'h0000, 10'd0, rand_word(), '0, 1'b0, '0, '0);
    add_row(FUNC_BEGIN, 1'b1, 4'h1, 13'h1FFE, 10'd1021, rand_word(), '0,
            1'b0, '0, '0);
    add_row(FUNC_BEGIN, 1'b0, 4'hE, 13'h0800, 10'd2, rand_word(), '0, 1'b0, '0, '0);
    add_row(FUNC_PAYLOAD, 1'b0, 4'h0, 13'h0000, 10'd0, '0, rand_word(), 1'b0, '0, '0);
    add_row(FUNC_PAYLOAD, 1'b0, 4'h0, 13'h0000, 10'd0, '0, rand_word(), 1'b0, '0, '0);

    foreach (directed_rows[i]) send_item(directed_rows[i]);
    drain_writes();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) run_random_event();

    drain_writes();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_writes.size() != 0) begin
      $error("%0d expected writes never arrived", pending_writes.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== flight_recorder_ring_writer.f =====
rtl/frw_pkg.sv
rtl/frw_ctrl.sv
rtl/frw_datapath.sv
rtl/flight_recorder_ring_writer.sv
tb/testbench.sv
